/* design/hsc_pkg.sv */
package hsc_pkg;

  localparam int CODE_BITS  = 72;
  localparam int CHECK_BITS = 8;
  localparam int DATA_BITS  = CODE_BITS - CHECK_BITS;
  localparam int SYN_CODES  = 1 << CHECK_BITS;

  localparam logic [7:0] NO_MATCH = 8'hFF;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_SYND   = 2'd1,
    OP_CAND   = 2'd2
  } op_t;

  // Rows of the circulant check matrix; H[r][c] = PCM_ROW[7-r][c].
  localparam logic [CODE_BITS-1:0] PCM_ROW [CHECK_BITS] = '{
    72'hFF_26_49_90_10_13_1C_E0_80,
    72'hE0_FF_26_49_90_10_13_1C_40,
    72'h1C_E0_FF_26_49_90_10_13_20,
    72'h13_1C_E0_FF_26_49_90_10_10,
    72'h10_13_1C_E0_FF_26_49_90_08,
    72'h90_10_13_1C_E0_FF_26_49_04,
    72'h49_90_10_13_1C_E0_FF_26_02,
    72'h26_49_90_10_13_1C_E0_FF_01
  };

  // All H columns packed, column c at [c*8 +: 8].
  function automatic logic [CODE_BITS*CHECK_BITS-1:0] build_cols();
    logic [CODE_BITS*CHECK_BITS-1:0] v;
    v = '0;
    for (int c = 0; c < CODE_BITS; c++) begin
      for (int r = 0; r < CHECK_BITS; r++) begin
        v[c*CHECK_BITS + r] = PCM_ROW[CHECK_BITS-1-r][c];
      end
    end
    return v;
  endfunction

  localparam logic [CODE_BITS*CHECK_BITS-1:0] H_COLS = build_cols();

  // Syndrome value -> lowest matching column, NO_MATCH if none.
  function automatic logic [SYN_CODES*8-1:0] build_pos();
    logic [SYN_CODES*8-1:0] v;
    logic [CHECK_BITS-1:0]  hc;
    v = {SYN_CODES{NO_MATCH}};
    for (int c = CODE_BITS - 1; c >= 0; c--) begin
      hc = H_COLS[c*CHECK_BITS +: CHECK_BITS];
      v[hc*8 +: 8] = 8'(c);
    end
    return v;
  endfunction

  localparam logic [SYN_CODES*8-1:0] POS_TBL = build_pos();

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] syn;    // syndrome (ops 0/1) or input syndrome (op 2)
    logic [7:0] xs;     // syndrome xor trial column
    logic [7:0] hc;     // trial column
    logic       col_ok;
  } s1_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] syn;
    logic [7:0] pos_syn;
    logic [7:0] pos_xs;
    logic [7:0] pos_hc;
    logic       col_ok;
  } s2_t;

endpackage

/* design/hsc_syn.sv */
module hsc_syn (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [1:0]                    op,
  input  logic [hsc_pkg::DATA_BITS-1:0] data_bits,
  input  logic [7:0]                    check_bits,
  input  logic [6:0]                    column_index,
  output logic                          v_r,
  output hsc_pkg::s1_t                  s1_r
);
  import hsc_pkg::*;

  logic [CODE_BITS-1:0]  word;
  logic [CHECK_BITS-1:0] syn;
  logic                  col_ok;
  logic [CHECK_BITS-1:0] hc;
  s1_t                   s1_nxt;

  // encode uses zero check bits
  assign word = {data_bits, (op == OP_ENCODE) ? 8'h00 : check_bits};

  always_comb begin
    for (int r = 0; r < CHECK_BITS; r++) begin
      syn[r] = ^(word & PCM_ROW[CHECK_BITS-1-r]);
    end
  end

  assign col_ok = (column_index < 7'(CODE_BITS));
  assign hc     = col_ok ? H_COLS[{column_index, 3'b000} +: CHECK_BITS] : '0;

  always_comb begin
    s1_nxt.op     = op;
    s1_nxt.syn    = (op == OP_CAND) ? check_bits : syn;
    s1_nxt.xs     = hc ^ check_bits;
    s1_nxt.hc     = hc;
    s1_nxt.col_ok = col_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

/* design/hsc_lkp.sv */
module hsc_lkp (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_in,
  input  hsc_pkg::s1_t s1,
  output logic         v_r,
  output hsc_pkg::s2_t s2_r
);
  import hsc_pkg::*;

  s2_t s2_nxt;

  // three parallel reads of the syndrome-to-column table
  always_comb begin
    s2_nxt.op      = s1.op;
    s2_nxt.syn     = s1.syn;
    s2_nxt.pos_syn = POS_TBL[{s1.syn, 3'b000} +: 8];
    s2_nxt.pos_xs  = POS_TBL[{s1.xs,  3'b000} +: 8];
    s2_nxt.pos_hc  = POS_TBL[{s1.hc,  3'b000} +: 8];
    s2_nxt.col_ok  = s1.col_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (v_in) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

/* design/hsc_sel.sv */
module hsc_sel (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         v_in,
  input  hsc_pkg::s2_t s2,
  output logic         out_valid_r,
  output logic [7:0]   check_out_r,
  output logic [7:0]   first_pos_r,
  output logic [7:0]   second_pos_r
);
  import hsc_pkg::*;

  logic [7:0] check_nxt;
  logic [7:0] first_nxt;
  logic [7:0] second_nxt;

  always_comb begin
    check_nxt  = '0;
    first_nxt  = '0;
    second_nxt = '0;
    case (s2.op)
      OP_ENCODE: begin
        check_nxt = s2.syn;
      end
      OP_SYND: begin
        check_nxt = s2.syn;
        first_nxt = s2.pos_syn;
      end
      OP_CAND: begin
        check_nxt = s2.syn;
        if (!s2.col_ok) begin
          first_nxt  = NO_MATCH;
          second_nxt = NO_MATCH;
        end else if (s2.pos_xs == NO_MATCH) begin
          // no partner: fall back to single-error position
          first_nxt  = s2.pos_syn;
          second_nxt = s2.pos_syn;
        end else begin
          first_nxt  = s2.pos_hc;
          second_nxt = s2.pos_xs;
        end
      end
      default: begin
        check_nxt  = '0;
        first_nxt  = '0;
        second_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (v_in) begin
      check_out_r  <= check_nxt;
      first_pos_r  <= first_nxt;
      second_pos_r <= second_nxt;
    end
  end

endmodule

/* design/hsiao_secded_72_64_codec.sv */
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  ---------------------------
// input     in_op, in_data_bits, in_check_bits,           start && !busy
//           in_column_index
// result    out_check_out, out_first_position,            out_valid, one cycle, no stall
//           out_second_position
//
// One transaction per cycle; each result reaches the out_ ports through three
// register stages: syndrome/XOR tree, column table lookups, result selection.
// busy is tied low: the receiver cannot stall, so nothing ever backs up.
// rst_n (synchronous, active low) clears the valid bits of all stages.
module hsiao_secded_72_64_codec (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_op,
  input  logic [hsc_pkg::DATA_BITS-1:0] in_data_bits,
  input  logic [7:0]                    in_check_bits,
  input  logic [6:0]                    in_column_index,
  output logic                          out_valid,
  output logic [7:0]                    out_check_out,
  output logic [7:0]                    out_first_position,
  output logic [7:0]                    out_second_position
);
  import hsc_pkg::*;

  logic acc;
  logic v1_r;
  logic v2_r;
  s1_t  s1_r;
  s2_t  s2_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Stage 1: syndrome parity tree, trial column fetch and xor
  hsc_syn u_syn (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .op           (in_op),
    .data_bits    (in_data_bits),
    .check_bits   (in_check_bits),
    .column_index (in_column_index),
    .v_r          (v1_r),
    .s1_r         (s1_r)
  );

  // Stage 2: syndrome -> column position lookups
  hsc_lkp u_lkp (
    .clk   (clk),
    .rst_n (rst_n),
    .v_in  (v1_r),
    .s1    (s1_r),
    .v_r   (v2_r),
    .s2_r  (s2_r)
  );

  // Stage 3: per-op result selection into the output registers
  hsc_sel u_sel (
    .clk          (clk),
    .rst_n        (rst_n),
    .v_in         (v2_r),
    .s2           (s2_r),
    .out_valid_r  (out_valid),
    .check_out_r  (out_check_out),
    .first_pos_r  (out_first_position),
    .second_pos_r (out_second_position)
  );

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without a transaction three cycles earlier");

  a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_first_position != NO_MATCH) |-> out_first_position < 8'(CODE_BITS))
    else $error("first_position outside column range");

  a_second_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_second_position != NO_MATCH) |-> out_second_position < 8'(CODE_BITS))
    else $error("second_position outside column range");
`endif

endmodule
